// ----- sv/klock_pkg.sv -----
// ----------------------------------------------------------------------------
// klock_pkg
// Shared types, codes and the keypad symbol map for the code lock controller.
// ----------------------------------------------------------------------------
package klock_pkg;

	localparam int CODE_DIGITS = 4;
	localparam int ENTRY_LEN   = CODE_DIGITS + 1;
	localparam int CODE_W      = 4 * CODE_DIGITS;
	localparam int KPOS_W      = $clog2(ENTRY_LEN);

	typedef logic [3:0]        sym_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [KPOS_W-1:0] kpos_t;
	typedef logic [2:0]        status_t;
	typedef logic [1:0]        func_t;
	typedef logic [1:0]        cfg_idx_t;

	// Symbols
	localparam sym_t SYM_STAR = 4'd10;
	localparam sym_t SYM_HASH = 4'd11;
	localparam sym_t SYM_NONE = 4'd15;

	// Event kinds
	localparam func_t FN_KEY   = 2'd0;
	localparam func_t FN_REPLY = 2'd1;
	localparam func_t FN_TICK  = 2'd2;

	// Result status codes
	localparam status_t ST_IDLE        = 3'd0;
	localparam status_t ST_CODE_CHANGE = 3'd1;
	localparam status_t ST_REQ_SENT    = 3'd2;
	localparam status_t ST_DENIED      = 3'd3;
	localparam status_t ST_UNLOCKED    = 3'd4;
	localparam status_t ST_REMOTE_DENY = 3'd5;
	localparam status_t ST_LOCKED_OUT  = 3'd6;
	localparam status_t ST_RELOCKED    = 3'd7;

	// Configuration register indexes
	localparam cfg_idx_t CFG_MASTER_CODE = 2'd0;
	localparam cfg_idx_t CFG_FAIL_LIMIT  = 2'd1;
	localparam cfg_idx_t CFG_HOLD_TICKS  = 2'd2;

	// Reset values
	localparam logic [15:0] MASTER_RST    = 16'h2345;
	localparam logic [2:0]  FAIL_LIM_RST  = 3'd3;
	localparam logic [14:0] HOLD_RST      = 15'd20000;
	localparam logic [15:0] USER_CODE_RST = 16'h2345;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COLLECT,
		PH_MASTER_HASH,
		PH_NEWCODE,
		PH_AWAIT,
		PH_OPEN,
		PH_LOCKOUT
	} phase_t;

	typedef struct packed {
		func_t       func;
		logic [4:0]  key_index;
		logic        reply_approve;
		logic        sensor_high;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic        unlock;
		logic        request_line;
		logic        alarm;
		logic [2:0]  failures;
	} result_t;

	// Row-major keypad position to symbol; unused positions carry no symbol
	function automatic sym_t key_symbol(logic [4:0] idx);
		sym_t s;
		case (idx)
			5'd1:    s = 4'd1;
			5'd2:    s = 4'd2;
			5'd3:    s = 4'd3;
			5'd5:    s = 4'd4;
			5'd6:    s = 4'd5;
			5'd7:    s = 4'd6;
			5'd9:    s = 4'd7;
			5'd10:   s = 4'd8;
			5'd11:   s = 4'd9;
			5'd13:   s = SYM_STAR;
			5'd14:   s = 4'd0;
			5'd15:   s = SYM_HASH;
			default: s = SYM_NONE;
		endcase
		return s;
	endfunction

	// Master code right-aligned in the code word; extra leading digits are 0
	function automatic code_t master_to_code(logic [15:0] m);
		return code_t'(m);
	endfunction

endpackage

// ----- sv/klock_in_stage.sv -----
// ----------------------------------------------------------------------------
// klock_in_stage
// Input register: holds one event item until the core consumes it.
// ----------------------------------------------------------------------------
module klock_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  klock_pkg::item_t  in_item,
	input  logic              advance,
	output logic              valid_s1,
	output klock_pkg::item_t  item_s1
);

	logic valid_s1_q;

	assign in_ready = !valid_s1_q || advance;
	assign valid_s1 = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- sv/klock_core.sv -----
// ----------------------------------------------------------------------------
// klock_core
// Lock state machine, code storage and configuration registers. State moves
// at the edge where the staged item is handed to the result register.
// ----------------------------------------------------------------------------
module klock_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  klock_pkg::cfg_idx_t  cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 advance,
	input  klock_pkg::item_t     item,
	output klock_pkg::result_t   result
);

	logic [15:0]         master_q;
	logic [2:0]          fail_limit_q;
	logic [14:0]         hold_q;

	klock_pkg::phase_t   phase_q, phase_d;
	klock_pkg::kpos_t    kpos_q, kpos_d;
	klock_pkg::sym_t     entry_q [klock_pkg::ENTRY_LEN];
	klock_pkg::sym_t     entry_d [klock_pkg::ENTRY_LEN];
	klock_pkg::code_t    user_q, user_d;
	logic [2:0]          fail_q, fail_d;
	logic [14:0]         ticks_q, ticks_d;

	klock_pkg::sym_t     sym;
	klock_pkg::code_t    master_c;
	klock_pkg::code_t    new_code;
	logic                master_hit;
	logic                user_hit;
	logic                fail_now;
	logic [2:0]          fail_inc;
	logic [14:0]         ticks_inc;
	klock_pkg::status_t  status_c;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q     <= klock_pkg::MASTER_RST;
			fail_limit_q <= klock_pkg::FAIL_LIM_RST;
			hold_q       <= klock_pkg::HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				klock_pkg::CFG_MASTER_CODE: master_q     <= cfg_data;
				klock_pkg::CFG_FAIL_LIMIT:  fail_limit_q <= cfg_data[2:0];
				klock_pkg::CFG_HOLD_TICKS:  hold_q       <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= klock_pkg::PH_IDLE;
			kpos_q  <= '0;
			user_q  <= klock_pkg::code_t'(klock_pkg::USER_CODE_RST);
			fail_q  <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			kpos_q  <= kpos_d;
			user_q  <= user_d;
			fail_q  <= fail_d;
			ticks_q <= ticks_d;
		end
	end

	// entry buffer is always written before it is compared
	always_ff @(posedge clk) begin
		if (advance) begin
			entry_q <= entry_d;
		end
	end

	assign sym       = klock_pkg::key_symbol(item.key_index);
	assign master_c  = klock_pkg::master_to_code(master_q);
	assign fail_inc  = (fail_q == 3'd7) ? fail_q : fail_q + 3'd1;
	assign ticks_inc = ticks_q + 15'd1;

	always_comb begin
		master_hit = 1'b1;
		user_hit   = 1'b1;
		for (int k = 0; k < klock_pkg::CODE_DIGITS; k++) begin
			if (entry_q[k] != master_c[4*(klock_pkg::CODE_DIGITS-1-k) +: 4])
				master_hit = 1'b0;
			if (entry_q[k] != user_q[4*(klock_pkg::CODE_DIGITS-1-k) +: 4])
				user_hit = 1'b0;
		end
	end

	// new user code: stored digits plus the key arriving now as the last one
	always_comb begin
		for (int k = 0; k < klock_pkg::CODE_DIGITS; k++) begin
			new_code[4*(klock_pkg::CODE_DIGITS-1-k) +: 4] =
				(k == klock_pkg::CODE_DIGITS - 1) ? sym : entry_q[k];
		end
	end

	always_comb begin
		phase_d  = phase_q;
		kpos_d   = kpos_q;
		entry_d  = entry_q;
		user_d   = user_q;
		fail_d   = fail_q;
		ticks_d  = ticks_q;
		status_c = klock_pkg::ST_IDLE;
		fail_now = 1'b0;

		if (phase_q == klock_pkg::PH_LOCKOUT) begin
			status_c = klock_pkg::ST_LOCKED_OUT;
		end else if (item.func == klock_pkg::FN_KEY) begin
			case (phase_q)
				klock_pkg::PH_IDLE: begin
					if (sym != klock_pkg::SYM_STAR) begin
						fail_now = 1'b1;
					end else begin
						phase_d = klock_pkg::PH_COLLECT;
						kpos_d  = '0;
					end
				end
				klock_pkg::PH_COLLECT: begin
					entry_d[kpos_q] = sym;
					if (kpos_q != klock_pkg::kpos_t'(klock_pkg::ENTRY_LEN - 1)) begin
						kpos_d = kpos_q + 1'b1;
					end else begin
						kpos_d = '0;
						if (master_hit && sym == klock_pkg::SYM_STAR) begin
							phase_d = klock_pkg::PH_MASTER_HASH;
						end else if (user_hit && sym == klock_pkg::SYM_HASH) begin
							fail_d   = '0;
							phase_d  = klock_pkg::PH_AWAIT;
							status_c = klock_pkg::ST_REQ_SENT;
						end else begin
							fail_now = 1'b1;
						end
					end
				end
				klock_pkg::PH_MASTER_HASH: begin
					if (sym != klock_pkg::SYM_HASH) begin
						fail_now = 1'b1;
					end else begin
						phase_d = klock_pkg::PH_NEWCODE;
						kpos_d  = '0;
					end
				end
				klock_pkg::PH_NEWCODE: begin
					entry_d[kpos_q] = sym;
					if (kpos_q != klock_pkg::kpos_t'(klock_pkg::CODE_DIGITS - 1)) begin
						kpos_d = kpos_q + 1'b1;
					end else begin
						user_d   = new_code;
						kpos_d   = '0;
						fail_d   = '0;
						phase_d  = klock_pkg::PH_IDLE;
						status_c = klock_pkg::ST_CODE_CHANGE;
					end
				end
				default: ;
			endcase
		end else if (item.func == klock_pkg::FN_REPLY) begin
			if (phase_q == klock_pkg::PH_AWAIT) begin
				if (item.reply_approve) begin
					phase_d  = klock_pkg::PH_OPEN;
					ticks_d  = '0;
					status_c = klock_pkg::ST_UNLOCKED;
				end else begin
					phase_d  = klock_pkg::PH_IDLE;
					status_c = klock_pkg::ST_REMOTE_DENY;
				end
			end
		end else if (item.func == klock_pkg::FN_TICK) begin
			if (phase_q == klock_pkg::PH_OPEN) begin
				if (!item.sensor_high) begin
					phase_d  = klock_pkg::PH_IDLE;
					status_c = klock_pkg::ST_RELOCKED;
				end else begin
					ticks_d = ticks_inc;
					// wrap to zero counts as expiry too
					if (ticks_inc >= hold_q || ticks_inc == '0) begin
						phase_d  = klock_pkg::PH_IDLE;
						status_c = klock_pkg::ST_RELOCKED;
					end
				end
			end
		end

		if (fail_now) begin
			fail_d = fail_inc;
			kpos_d = '0;
			if (fail_inc >= fail_limit_q) begin
				phase_d  = klock_pkg::PH_LOCKOUT;
				status_c = klock_pkg::ST_LOCKED_OUT;
			end else begin
				phase_d  = klock_pkg::PH_IDLE;
				status_c = klock_pkg::ST_DENIED;
			end
		end
	end

	always_comb begin
		result.status       = status_c;
		result.unlock       = (phase_d == klock_pkg::PH_OPEN);
		result.request_line = (phase_d == klock_pkg::PH_AWAIT);
		result.alarm        = (phase_d == klock_pkg::PH_LOCKOUT);
		result.failures     = fail_d;
	end

endmodule

// ----- sv/klock_out_stage.sv -----
// ----------------------------------------------------------------------------
// klock_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module klock_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  klock_pkg::result_t  result,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_ready,
	output klock_pkg::result_t  out_result
);

	logic               out_valid_q;
	klock_pkg::result_t res_q;

	assign advance    = valid_s1 && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

endmodule

// ----- sv/keypad_code_lock_controller.sv -----
// Path: the input register holds an accepted item until its result enters the result register.
// Throughput: one item per cycle unless out_ready stalls; each event resolves in one pass.
// Reset (arst_n low, async): lock idle, failures 0, alarm clear, user code and
// master code 2345, fail limit 3, hold 20000 ticks; both stages empty.
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Keypad code lock: code entry, access request, remote reply, timed opening.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [4:0]  key_index,
	input  logic        reply_approve,
	input  logic        sensor_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        unlock,
	output logic        request_line,
	output logic        alarm,
	output logic [2:0]  failures
);

	klock_pkg::item_t   in_item;
	klock_pkg::item_t   item_s1;
	klock_pkg::result_t result;
	klock_pkg::result_t out_result;
	logic               valid_s1;
	logic               advance;

	always_comb begin
		in_item.func          = func;
		in_item.key_index     = key_index;
		in_item.reply_approve = reply_approve;
		in_item.sensor_high   = sensor_high;
	end

	klock_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	klock_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.item      (item_s1),
		.result    (result)
	);

	klock_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.result     (result),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_result (out_result)
	);

	assign status       = out_result.status;
	assign unlock       = out_result.unlock;
	assign request_line = out_result.request_line;
	assign alarm        = out_result.alarm;
	assign failures     = out_result.failures;

endmodule

// ----- tb/keypad_code_lock_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_tb
// Checks the code lock against a cycle-free predictor of its state machine.
// Key, reply and tick items are mostly well-formed attempts (access, code
// change, reply, door ticks) with random content, mixed with broken attempts
// and noise. Each accepted item is predicted; each result is compared with
// the oldest prediction. Both sides idle at random, and the receiver holds
// off long enough to fill the block. The lockout is entered only at the end.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_tb;
	import klock_pkg::*;

	localparam int WATCHDOG  = 2000;
	localparam int HOLD_OFF  = 200;
	localparam int PHASE_LEN = 130;

	// ------------------------------------------------------------------------
	// Lock predictor and result store
	// ------------------------------------------------------------------------
	class lock_scoreboard;
		code_t       master_cd;
		logic [2:0]  flimit;
		logic [14:0] hold;
		phase_t      phase;
		int          kpos;
		sym_t        entry[ENTRY_LEN];
		code_t       user_cd;
		logic [2:0]  fails;
		logic [14:0] open_cnt;
		result_t     pending_results[$];
		int          errors;
		int          n_checked;

		function new();
			master_cd = code_t'(MASTER_RST);
			flimit    = FAIL_LIM_RST;
			hold      = HOLD_RST;
			phase     = PH_IDLE;
			kpos      = 0;
			foreach (entry[k]) entry[k] = '0;
			user_cd   = code_t'(USER_CODE_RST);
			fails     = '0;
			open_cnt  = '0;
			errors    = 0;
			n_checked = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] v);
			case (idx)
				CFG_MASTER_CODE: master_cd = code_t'(v);
				CFG_FAIL_LIMIT:  flimit = v[2:0];
				CFG_HOLD_TICKS:  hold = v[14:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function sym_t sym_of(logic [4:0] k);
			case (k)
				5'd1:    return 4'd1;
				5'd2:    return 4'd2;
				5'd3:    return 4'd3;
				5'd5:    return 4'd4;
				5'd6:    return 4'd5;
				5'd7:    return 4'd6;
				5'd9:    return 4'd7;
				5'd10:   return 4'd8;
				5'd11:   return 4'd9;
				5'd13:   return SYM_STAR;
				5'd14:   return 4'd0;
				5'd15:   return SYM_HASH;
				default: return SYM_NONE;
			endcase
		endfunction

		function bit entry_is(code_t c);
			for (int k = 0; k < CODE_DIGITS; k++)
				if (entry[k] != c[4*(CODE_DIGITS-1-k) +: 4])
					return 0;
			return 1;
		endfunction

		function status_t fail_attempt();
			if (fails != 3'd7)
				fails++;
			phase = PH_IDLE;
			kpos  = 0;
			if (fails >= flimit) begin
				phase = PH_LOCKOUT;
				return ST_LOCKED_OUT;
			end
			return ST_DENIED;
		endfunction

		function status_t press_key(sym_t s);
			case (phase)
				PH_IDLE: begin
					if (s != SYM_STAR)
						return fail_attempt();
					phase = PH_COLLECT;
					kpos  = 0;
					return ST_IDLE;
				end
				PH_COLLECT: begin
					entry[kpos] = s;
					kpos++;
					if (kpos < ENTRY_LEN)
						return ST_IDLE;
					kpos = 0;
					// master entry takes precedence over a user access
					if (entry_is(master_cd) && entry[CODE_DIGITS] == SYM_STAR) begin
						phase = PH_MASTER_HASH;
						return ST_IDLE;
					end
					if (entry_is(user_cd) && entry[CODE_DIGITS] == SYM_HASH) begin
						fails = '0;
						phase = PH_AWAIT;
						return ST_REQ_SENT;
					end
					return fail_attempt();
				end
				PH_MASTER_HASH: begin
					if (s != SYM_HASH)
						return fail_attempt();
					phase = PH_NEWCODE;
					kpos  = 0;
					return ST_IDLE;
				end
				PH_NEWCODE: begin
					entry[kpos] = s;
					kpos++;
					if (kpos < CODE_DIGITS)
						return ST_IDLE;
					user_cd = '0;
					for (int k = 0; k < CODE_DIGITS; k++)
						user_cd = {user_cd[CODE_W-5:0], entry[k]};
					kpos  = 0;
					fails = '0;
					phase = PH_IDLE;
					return ST_CODE_CHANGE;
				end
				default: return ST_IDLE;
			endcase
		endfunction

		function void note_input(item_t it);
			status_t st;
			result_t res;
			st = ST_IDLE;
			if (phase == PH_LOCKOUT) begin
				st = ST_LOCKED_OUT;
			end else begin
				case (it.func)
					FN_KEY: st = press_key(sym_of(it.key_index));
					FN_REPLY: begin
						if (phase == PH_AWAIT) begin
							if (it.reply_approve) begin
								phase    = PH_OPEN;
								open_cnt = '0;
								st       = ST_UNLOCKED;
							end else begin
								phase = PH_IDLE;
								st    = ST_REMOTE_DENY;
							end
						end
					end
					FN_TICK: begin
						if (phase == PH_OPEN) begin
							if (!it.sensor_high) begin
								phase = PH_IDLE;
								st    = ST_RELOCKED;
							end else begin
								open_cnt++;
								// 15-bit wrap also relocks
								if (open_cnt >= hold || open_cnt == '0) begin
									phase = PH_IDLE;
									st    = ST_RELOCKED;
								end
							end
						end
					end
					default: ;
				endcase
			end
			res.status       = st;
			res.unlock       = (phase == PH_OPEN);
			res.request_line = (phase == PH_AWAIT);
			res.alarm        = (phase == PH_LOCKOUT);
			res.failures     = fails;
			pending_results.push_back(res);
		endfunction

		function void cmp_field(string name, int e, int g);
			if (e != g) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, g);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, got.status);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			cmp_field("status", exp.status, got.status);
			cmp_field("unlock", exp.unlock, got.unlock);
			cmp_field("request_line", exp.request_line, got.request_line);
			cmp_field("alarm", exp.alarm, got.alarm);
			cmp_field("failures", exp.failures, got.failures);
			n_checked++;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and signals
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [4:0]  key_index;
	logic        reply_approve;
	logic        sensor_high;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic        unlock;
	logic        request_line;
	logic        alarm;
	logic [2:0]  failures;

	lock_scoreboard sb = new();

	item_t plan_q[$];
	bit    plan_safe;
	int    burst_left;
	int    idle_cycles = 0;

	keypad_code_lock_controller uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.key_index     (key_index),
		.reply_approve (reply_approve),
		.sensor_high   (sensor_high),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.unlock        (unlock),
		.request_line  (request_line),
		.alarm         (alarm),
		.failures      (failures)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------------
	function automatic sym_t rand_sym();
		int r;
		r = $urandom_range(0, 12);
		return (r == 12) ? SYM_NONE : sym_t'(r);
	endfunction

	function automatic logic [4:0] key_for(sym_t s);
		case (s)
			4'd0:     return 5'd14;
			4'd1:     return 5'd1;
			4'd2:     return 5'd2;
			4'd3:     return 5'd3;
			4'd4:     return 5'd5;
			4'd5:     return 5'd6;
			4'd6:     return 5'd7;
			4'd7:     return 5'd9;
			4'd8:     return 5'd10;
			4'd9:     return 5'd11;
			SYM_STAR: return 5'd13;
			SYM_HASH: return 5'd15;
			default: begin
				// any position without a symbol
				case ($urandom_range(0, 5))
					0:       return 5'd0;
					1:       return 5'd4;
					2:       return 5'd8;
					3:       return 5'd12;
					4:       return 5'd16;
					default: return 5'($urandom_range(17, 31));
				endcase
			end
		endcase
	endfunction

	function automatic item_t blank_item(func_t f);
		item_t it;
		it.func          = f;
		it.key_index     = 5'($urandom_range(0, 31));
		it.reply_approve = 1'($urandom_range(0, 1));
		it.sensor_high   = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void push_raw(logic [4:0] idx);
		item_t it;
		it = blank_item(FN_KEY);
		it.key_index = idx;
		plan_q.push_back(it);
	endfunction

	function automatic void push_sym(sym_t s);
		push_raw(key_for(s));
	endfunction

	function automatic void push_code(code_t c);
		for (int k = 0; k < CODE_DIGITS; k++)
			push_sym(c[4*(CODE_DIGITS-1-k) +: 4]);
	endfunction

	function automatic void push_reply(bit approve);
		item_t it;
		it = blank_item(FN_REPLY);
		it.reply_approve = approve;
		plan_q.push_back(it);
	endfunction

	function automatic void push_tick(bit sensor);
		item_t it;
		it = blank_item(FN_TICK);
		it.sensor_high = sensor;
		plan_q.push_back(it);
	endfunction

	function automatic void push_noise();
		plan_q.push_back(blank_item(func_t'($urandom_range(0, 3))));
	endfunction

	function automatic code_t rand_code();
		code_t c;
		c = '0;
		for (int k = 0; k < CODE_DIGITS; k++)
			c = {c[CODE_W-5:0], rand_sym()};
		return c;
	endfunction

	function automatic void plan_access();
		push_sym(SYM_STAR);
		push_code(sb.user_cd);
		push_sym(SYM_HASH);
	endfunction

	// well-formed attempt with one key replaced at random
	function automatic void plan_broken();
		sym_t seq[ENTRY_LEN];
		code_t c;
		bit use_master;
		use_master = ($urandom_range(0, 2) == 0);
		c = use_master ? sb.master_cd : sb.user_cd;
		for (int k = 0; k < CODE_DIGITS; k++)
			seq[k] = c[4*(CODE_DIGITS-1-k) +: 4];
		seq[CODE_DIGITS] = use_master ? SYM_STAR : SYM_HASH;
		seq[$urandom_range(0, ENTRY_LEN-1)] = rand_sym();
		push_sym(SYM_STAR);
		foreach (seq[k]) push_sym(seq[k]);
	endfunction

	function automatic void choose_plan();
		int r;
		r = $urandom_range(0, 99);
		case (sb.phase)
			PH_IDLE: begin
				if (r < 35) begin
					plan_access();
				end else if (r < 50) begin
					push_sym(SYM_STAR);
					push_code(sb.master_cd);
					push_sym(SYM_STAR);
					push_sym(SYM_HASH);
					push_code(rand_code());
				end else if (r < 68) begin
					plan_broken();
				end else if (r < 76) begin
					// master entry then a random third key
					push_sym(SYM_STAR);
					push_code(sb.master_cd);
					push_sym(SYM_STAR);
					push_sym(rand_sym());
				end else if (r < 86) begin
					push_sym(rand_sym());
				end else begin
					push_noise();
				end
			end
			PH_COLLECT, PH_MASTER_HASH, PH_NEWCODE: begin
				if (r < 75)
					push_sym(rand_sym());
				else
					push_noise();
			end
			PH_AWAIT: begin
				if (r < 20)
					push_noise();
				else
					push_reply(r >= 40);
			end
			PH_OPEN: begin
				if (r < 15)
					push_noise();
				else
					push_tick(r >= 22);
			end
			default: push_noise();
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	task automatic idle_input(int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_item(item_t it);
		int gap;
		@(negedge clk);
		in_valid      = 1'b1;
		func          = it.func;
		key_index     = it.key_index;
		reply_approve = it.reply_approve;
		sensor_high   = it.sensor_high;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(it);
		gap = pick_gap();
		if (gap != 0)
			idle_input(gap);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		idle_input(1);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// In guarded runs, a failure that would reach the limit is never risked:
	// near the limit an idle lock gets a correct access, which clears the count.
	task automatic run_items(int n, bit guarded);
		int i;
		i = 0;
		while (i < n || (guarded && (plan_q.size() != 0 || sb.phase != PH_IDLE))) begin
			if (plan_q.size() == 0)
				plan_safe = 1'b0;
			if (guarded && sb.phase == PH_IDLE && !plan_safe &&
			    int'(sb.fails) >= int'(sb.flimit) - 2) begin
				plan_q.delete();
				plan_safe = 1'b1;
				plan_access();
			end
			if (plan_q.size() == 0)
				choose_plan();
			send_item(plan_q.pop_front());
			i++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [15:0] mc[6];
		logic [15:0] fl[6];
		logic [15:0] ht[6];

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_MASTER_CODE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		func          = FN_KEY;
		key_index     = '0;
		reply_approve = 1'b0;
		sensor_high   = 1'b0;
		plan_safe     = 1'b0;
		burst_left    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset configuration (limit 3)
		push_raw(5'd16);                   // unmapped key as first key
		push_sym(SYM_STAR);                // master, '*', then not '#'
		push_code(code_t'(MASTER_RST));
		push_sym(SYM_STAR);
		push_sym(4'd1);
		push_sym(SYM_STAR);                // code change to "#", none, "*", "0"
		push_code(code_t'(MASTER_RST));
		push_sym(SYM_STAR);
		push_sym(SYM_HASH);
		push_sym(SYM_HASH);
		push_raw(5'd0);
		push_sym(SYM_STAR);
		push_sym(4'd0);
		push_sym(SYM_STAR);                // access with the new code
		push_sym(SYM_HASH);
		push_raw(5'd31);
		push_sym(SYM_STAR);
		push_sym(4'd0);
		push_sym(SYM_HASH);
		push_reply(1'b1);
		push_tick(1'b1);
		push_tick(1'b0);
		while (plan_q.size() != 0)
			send_item(plan_q.pop_front());

		mc = '{16'h0000, 16'hFFFF, 16'($urandom), rand_code(), 16'hAAAA, rand_code()};
		fl = '{16'd7, 16'd1, 16'd4, 16'd7, 16'd5, 16'($urandom_range(4, 7))};
		ht = '{16'd0, 16'd32767, 16'd1, 16'd3, 16'd20000, 16'($urandom_range(1, 12))};
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_MASTER_CODE, mc[p]);
			write_reg(CFG_FAIL_LIMIT, fl[p]);
			write_reg(CFG_HOLD_TICKS, ht[p]);
			run_items(PHASE_LEN, 1'b1);
		end

		// Zero limit: the first failure latches the alarm for good
		write_reg(CFG_MASTER_CODE, rand_code());
		write_reg(CFG_FAIL_LIMIT, 16'd0);
		write_reg(CFG_HOLD_TICKS, 16'($urandom_range(1, 8)));
		run_items(40, 1'b0);

		idle_input(1);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls plus long hold-offs to back up the input
	// ------------------------------------------------------------------------
	initial begin
		int r;
		int n;
		int next_hold;
		out_ready = 1'b0;
		next_hold = 250;
		wait (arst_n === 1'b1);
		forever begin
			if (sb.n_checked >= next_hold) begin
				out_ready = 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				next_hold += 300;
			end
			r = $urandom_range(0, 99);
			if (r < 65) begin
				out_ready = 1'b1;
				n = $urandom_range(1, 24);
			end else if (r < 93) begin
				out_ready = 1'b0;
				n = $urandom_range(1, 3);
			end else begin
				out_ready = 1'b0;
				n = $urandom_range(8, 40);
			end
			repeat (n) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(result_t'({status, unlock, request_line, alarm, failures}));
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG);
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
sv/klock_pkg.sv
sv/klock_in_stage.sv
sv/klock_core.sv
sv/klock_out_stage.sv
sv/keypad_code_lock_controller.sv
tb/keypad_code_lock_controller_tb.sv
